/* sv/pidaw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types and codes of the PID controller with conditional integration:
// beat layouts of the sample and result channels, register indexes, commands.
// ----------------------------------------------------------------------------
package pidaw_pkg;

	// configuration port geometry
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_OUT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX  = 3'd6;

	// sample commands
	localparam logic FUNC_STEP  = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	// one sample beat
	typedef struct packed {
		logic               func;
		logic signed [15:0] measurement;
		logic        [19:0] elapsed_us;
	} item_t;

	// one result beat
	typedef struct packed {
		logic signed [15:0] drive;
		logic               clamped_low;
		logic               clamped_high;
	} result_t;

endpackage
`default_nettype wire

/* sv/pidaw_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pidaw_mul
// Bit-serial signed multiplier: shift-add over the multiplier b, one bit per
// cycle, LSB first, with a negative-weight last bit when b is signed.
// ----------------------------------------------------------------------------
module pidaw_mul #(
	parameter int unsigned AW      = 16,
	parameter int unsigned BW      = 16,
	parameter bit          BSIGNED = 1'b1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [AW-1:0]        a,
	input  wire logic [BW-1:0]        b,
	output logic                      busy,
	output logic      [AW+BW-1:0]     p
);
	localparam int unsigned CW = $clog2(BW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] a_q;
	logic [AW:0]   hi_q;
	logic [BW-1:0] lo_q;

	logic          last;
	logic          sub;
	logic [AW:0]   addend;
	logic [AW+1:0] sum;

	// one partial product step, subtract on the sign bit of b
	assign last   = (cnt_q == CW'(BW - 1));
	assign sub    = BSIGNED && last;
	assign addend = lo_q[0] ? {a_q[AW-1], a_q} : '0;
	assign sum    = sub ? ({hi_q[AW], hi_q} - {addend[AW], addend})
	                    : ({hi_q[AW], hi_q} + {addend[AW], addend});

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// product shift register
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[AW+1:1];
			lo_q <= {sum[0], lo_q[BW-1:1]};
		end
	end

	assign busy = busy_q;
	assign p    = {hi_q[AW-1:0], lo_q};

endmodule
`default_nettype wire

/* sv/pid_controller_antiwindup.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// PID control step with a saturating 48-bit integrator and conditional
// integration: a clamped drive leaves the integrator where it was.
// ----------------------------------------------------------------------------
// A control step runs from the accepted sample beat until the result beat
// stands in the output register, and the next sample is taken in that
// same cycle; a clear command returns no beat and leaves the block idle.
// The step length is set by the serial datapath: three bit-serial
// multiplies (error times elapsed time, kp, kd) run side by side, then the
// 48-step restoring divider for the derivative runs beside the 48-bit serial
// ki multiply, and the adds and clamping follow in ST_SUM1, ST_SUM2, ST_SUM3
// and ST_OUT. A finished result waits in the output register without holding
// up the next sample. Configuration writes are taken every cycle (cfg_ready
// is always high) and belong to times when no step is in flight.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [pidaw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pidaw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                             item_valid,
	output logic                                  item_ready,
	input  wire pidaw_pkg::item_t                 item,
	output logic                                  result_valid,
	input  wire logic                             result_ready,
	output pidaw_pkg::result_t                    result
);
	import pidaw_pkg::*;

	localparam int unsigned ERR_W   = 17;
	localparam int unsigned DIFF_W  = 18;
	localparam int unsigned EL_W    = 20;
	localparam int unsigned INT_W   = 48;
	localparam int unsigned KP_W    = 16;
	localparam int unsigned KI_W    = 32;
	localparam int unsigned KD_W    = 32;
	localparam int unsigned ERREL_W = EL_W + 1 + ERR_W;
	localparam int unsigned KPP_W   = KP_W + ERR_W;
	localparam int unsigned KDP_W   = KD_W + DIFF_W;
	localparam int unsigned KIP_W   = KI_W + INT_W;
	localparam int unsigned DIV_W   = 48;
	localparam int unsigned DCNT_W  = $clog2(DIV_W);
	localparam int unsigned PT_W    = KPP_W + 1 - 8;
	localparam int unsigned SUM_W   = 52;

	localparam logic [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
	localparam logic [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_INTEG,
		ST_MUL2,
		ST_SUM1,
		ST_SUM2,
		ST_SUM3,
		ST_OUT
	} state_t;

	// configuration registers
	logic signed [15:0]   setpoint_q;
	logic signed [KP_W-1:0] kp_q;
	logic signed [KI_W-1:0] ki_q;
	logic signed [KD_W-1:0] kd_q;
	logic signed [15:0]   base_q;
	logic signed [15:0]   out_min_q;
	logic signed [15:0]   out_max_q;

	// control state and output register
	state_t               state_q;
	logic                 res_valid_q;
	result_t              res_q;
	logic [INT_W-1:0]     integral_q;
	logic [ERR_W-1:0]     prev_q;

	// step payload
	logic [ERR_W-1:0]     err_q;
	logic [EL_W-1:0]      el_q;
	logic [INT_W-1:0]     nint_q;
	logic signed [SUM_W-1:0] part_q;
	logic signed [SUM_W-1:0] dterm_q;
	logic signed [SUM_W-1:0] total_q;

	// divider
	logic                 div_busy_q;
	logic [DCNT_W-1:0]    div_cnt_q;
	logic [EL_W-1:0]      rem_q;
	logic [DIV_W-1:0]     quo_q;

	logic                 cfg_fire;
	logic                 item_fire;
	logic                 step_fire;
	logic                 res_load;
	logic [ERR_W-1:0]     err_n;
	logic [DIFF_W-1:0]    diff_n;
	logic                 errel_busy;
	logic                 kp_busy;
	logic                 kd_busy;
	logic                 ki_busy;
	logic [ERREL_W-1:0]   errel_p;
	logic [KPP_W-1:0]     kp_p;
	logic [KDP_W-1:0]     kd_p;
	logic [KIP_W-1:0]     ki_p;
	logic                 mul_done;
	logic                 div_start;
	logic [INT_W:0]       int_sum;
	logic [INT_W-1:0]     nint_n;
	logic [KDP_W-1:0]     kd_mag;
	logic [EL_W:0]        div_shift;
	logic [EL_W+1:0]      div_trial;
	logic                 div_fits;
	logic [KPP_W:0]       kp_round;
	logic signed [PT_W-1:0] pterm;
	logic signed [INT_W-1:0] iterm;
	logic signed [SUM_W-1:0] min_x;
	logic signed [SUM_W-1:0] max_x;
	logic signed [SUM_W-1:0] after_lo;
	logic signed [SUM_W-1:0] drive_x;
	logic                 clamp_lo;
	logic                 clamp_hi;

	// handshakes
	assign cfg_ready    = 1'b1;
	assign cfg_fire     = cfg_valid && cfg_ready;
	assign item_ready   = (state_q == ST_IDLE);
	assign item_fire    = item_valid && item_ready;
	assign step_fire    = item_fire && (item.func == FUNC_STEP);
	assign res_load     = (state_q == ST_OUT) && (!res_valid_q || result_ready);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// error and error change of the incoming sample
	assign err_n  = {setpoint_q[15], setpoint_q} - {item.measurement[15], item.measurement};
	assign diff_n = {err_n[ERR_W-1], err_n} - {prev_q[ERR_W-1], prev_q};

	// serial multipliers
	pidaw_mul #(.AW(EL_W + 1), .BW(ERR_W), .BSIGNED(1'b1)) u_mul_errel (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (step_fire),
		.a      ({1'b0, item.elapsed_us}),
		.b      (err_n),
		.busy   (errel_busy),
		.p      (errel_p)
	);

	pidaw_mul #(.AW(KP_W), .BW(ERR_W), .BSIGNED(1'b1)) u_mul_kp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (step_fire),
		.a      (kp_q),
		.b      (err_n),
		.busy   (kp_busy),
		.p      (kp_p)
	);

	pidaw_mul #(.AW(KD_W), .BW(DIFF_W), .BSIGNED(1'b1)) u_mul_kd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (step_fire),
		.a      (kd_q),
		.b      (diff_n),
		.busy   (kd_busy),
		.p      (kd_p)
	);

	pidaw_mul #(.AW(KI_W), .BW(INT_W), .BSIGNED(1'b1)) u_mul_ki (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_INTEG),
		.a      (ki_q),
		.b      (nint_q),
		.busy   (ki_busy),
		.p      (ki_p)
	);

	assign mul_done  = !errel_busy && !kp_busy && !kd_busy;
	assign div_start = (state_q == ST_MUL1) && mul_done;

	// saturating integrator update
	assign int_sum = {integral_q[INT_W-1], integral_q}
	               + {{(INT_W + 1 - ERREL_W){errel_p[ERREL_W-1]}}, errel_p};
	assign nint_n  = (int_sum[INT_W] != int_sum[INT_W-1])
	               ? (int_sum[INT_W] ? INT_MIN : INT_MAX) : int_sum[INT_W-1:0];

	// restoring divider step on the derivative magnitude
	assign kd_mag    = kd_p[KDP_W-1] ? ('0 - kd_p) : kd_p;
	assign div_shift = {rem_q, quo_q[DIV_W-1]};
	assign div_trial = {1'b0, div_shift} - {2'b00, el_q};
	assign div_fits  = !div_trial[EL_W+1];

	// proportional term truncated toward zero, integral term floored
	assign kp_round = {kp_p[KPP_W-1], kp_p} + (kp_p[KPP_W-1] ? (KPP_W+1)'(255) : '0);
	assign pterm    = kp_round[KPP_W:8];
	assign iterm    = ki_p[KIP_W-1:KIP_W-INT_W];

	// low clamp first, high clamp last
	assign min_x    = SUM_W'(out_min_q);
	assign max_x    = SUM_W'(out_max_q);
	assign clamp_lo = (total_q < min_x);
	assign after_lo = clamp_lo ? min_x : total_q;
	assign clamp_hi = (after_lo > max_x);
	assign drive_x  = clamp_hi ? max_x : after_lo;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			kp_q       <= '0;
			ki_q       <= '0;
			kd_q       <= '0;
			base_q     <= '0;
			out_min_q  <= 16'sh8000;
			out_max_q  <= 16'sh7fff;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_SETPOINT: setpoint_q <= cfg_data[15:0];
				REG_KP_GAIN:  kp_q       <= cfg_data[KP_W-1:0];
				REG_KI_GAIN:  ki_q       <= cfg_data[KI_W-1:0];
				REG_KD_GAIN:  kd_q       <= cfg_data[KD_W-1:0];
				REG_BASE_OUT: base_q     <= cfg_data[15:0];
				REG_OUT_MIN:  out_min_q  <= cfg_data[15:0];
				REG_OUT_MAX:  out_max_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// step sequencer, controller state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			integral_q  <= '0;
			prev_q      <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_fire) begin
						if (item.func == FUNC_CLEAR) begin
							integral_q <= '0;
						end else begin
							state_q <= ST_MUL1;
						end
					end
				end
				ST_MUL1: begin
					if (mul_done) begin
						state_q <= ST_INTEG;
					end
				end
				ST_INTEG: state_q <= ST_MUL2;
				ST_MUL2: begin
					if (!ki_busy && !div_busy_q) begin
						state_q <= ST_SUM1;
					end
				end
				ST_SUM1: state_q <= ST_SUM2;
				ST_SUM2: state_q <= ST_SUM3;
				ST_SUM3: state_q <= ST_OUT;
				ST_OUT: begin
					if (res_load) begin
						res_q.drive        <= drive_x[15:0];
						res_q.clamped_low  <= clamp_lo;
						res_q.clamped_high <= clamp_hi;
						if (!clamp_lo && !clamp_hi) begin
							integral_q <= nint_q;
						end
						prev_q  <= err_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= '0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
			if (div_cnt_q == DCNT_W'(DIV_W - 1)) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (step_fire) begin
			err_q <= err_n;
			el_q  <= item.elapsed_us;
		end
		if (div_start) begin
			nint_q <= nint_n;
			rem_q  <= '0;
			quo_q  <= kd_mag[DIV_W-1:0];
		end else if (div_busy_q) begin
			rem_q <= div_fits ? div_trial[EL_W-1:0] : div_shift[EL_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], div_fits};
		end
		if (state_q == ST_SUM1) begin
			part_q <= SUM_W'(base_q) + SUM_W'(pterm);
			if (el_q == '0) begin
				dterm_q <= '0;
			end else if (kd_p[KDP_W-1]) begin
				dterm_q <= '0 - SUM_W'(quo_q);
			end else begin
				dterm_q <= SUM_W'(quo_q);
			end
		end
		if (state_q == ST_SUM2) begin
			part_q <= part_q + dterm_q;
		end
		if (state_q == ST_SUM3) begin
			total_q <= part_q + SUM_W'(iterm);
		end
	end

endmodule
`default_nettype wire

/* sv/pidaw_checks.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pidaw_checks
// Port-level checks of the PID controller: result beat holding, the
// one-step-at-a-time acceptance of samples and register writes while idle.
// ----------------------------------------------------------------------------
module pidaw_checks (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             cfg_valid,
	input wire logic                             cfg_ready,
	input wire logic [pidaw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input wire logic [pidaw_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic                             item_valid,
	input wire logic                             item_ready,
	input wire pidaw_pkg::item_t                 item,
	input wire logic                             result_valid,
	input wire logic                             result_ready,
	input wire pidaw_pkg::result_t               result
);
	import pidaw_pkg::*;

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// a control step occupies the block
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.func == FUNC_STEP) |=> !item_ready)
		else $error("sample taken during a control step");

	// a clear finishes at once
	a_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.func == FUNC_CLEAR) |=> item_ready)
		else $error("clear command stalled the sample channel");

	// a new result arrives as the step ends
	a_result_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> item_ready)
		else $error("result beat raised while a step is still running");

	// register writes land while the block is idle, with known index and data
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> item_ready && !$isunknown({cfg_index, cfg_data}))
		else $error("register write during a control step");

endmodule

bind pid_controller_antiwindup pidaw_checks u_pidaw_checks (.*);
`default_nettype wire
